/* hw/rtl/maq_pkg.sv */
package maq_pkg;

  localparam int NumChannels = 4;
  localparam int ChanW       = $clog2(NumChannels);
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 16;

  // A body sample only counts as a spike when there is no previous valid load or it was below this.
  localparam logic [9:0] CpuHighPrev = 10'd800;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SILENCE_LEVEL,
    REG_DROPOUT_COUNT,
    REG_AUDIO_MAX_RATIO,
    REG_FACE_BURST_LIMIT,
    REG_BRIGHTNESS_MAX_DELTA,
    REG_IGNORE_SELF,
    REG_FLAP_WINDOW_MS,
    REG_CPU_SPIKE_LEVEL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAL_VALID,
    QUAL_DROPOUT,
    QUAL_REJECTED,
    QUAL_OTHER
  } quality_e;

  typedef enum logic [2:0] {
    REASON_NONE,
    REASON_DROPOUT,
    REASON_LEVEL_JUMP,
    REASON_FACE_BURST,
    REASON_BRIGHTNESS,
    REASON_SELF,
    REASON_FLAP,
    REASON_CPU
  } reason_e;

  typedef enum logic [ChanW-1:0] {
    CH_AUDIO,
    CH_CAMERA,
    CH_SCREEN,
    CH_BODY
  } channel_e;

  typedef struct packed {
    logic             command;
    logic [ChanW-1:0] channel;
    logic [1:0]       in_quality;
    logic [15:0]      sample_value;
    logic [15:0]      raw_rms;
    logic             voiced;
    logic [5:0]       faces;
    logic             is_self_process;
    logic             text_present;
    logic [31:0]      now_ms;
    logic [9:0]       cpu_load;
  } item_t;

  typedef struct packed {
    logic [1:0]  quality;
    logic [2:0]  reason;
    logic [15:0] out_value;
    logic [5:0]  out_faces;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [15:0] silence_level;
    logic [15:0] dropout_count;
    logic [15:0] audio_max_ratio;
    logic [7:0]  face_burst_limit;
    logic [15:0] brightness_max_delta;
    logic        ignore_self;
    logic [15:0] flap_window_ms;
    logic [9:0]  cpu_spike_level;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    silence_level:        16'd328,
    dropout_count:        16'd10,
    audio_max_ratio:      16'd2560,
    face_burst_limit:     8'd3,
    brightness_max_delta: 16'd19661,
    ignore_self:          1'b1,
    flap_window_ms:       16'd500,
    cpu_spike_level:      10'd950
  };

endpackage

/* hw/rtl/maq_stream_if.sv */
interface maq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/maq_cfg_regs.sv */
module maq_cfg_regs import maq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  input  cfg_wr_t wr_i,
  output cfg_t    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (cfg_reg_e'(wr_i.index))
        REG_SILENCE_LEVEL:        cfg_d.silence_level        = wr_i.value;
        REG_DROPOUT_COUNT:        cfg_d.dropout_count        = wr_i.value;
        REG_AUDIO_MAX_RATIO:      cfg_d.audio_max_ratio      = wr_i.value;
        REG_FACE_BURST_LIMIT:     cfg_d.face_burst_limit     = wr_i.value[7:0];
        REG_BRIGHTNESS_MAX_DELTA: cfg_d.brightness_max_delta = wr_i.value;
        REG_IGNORE_SELF:          cfg_d.ignore_self          = wr_i.value[0];
        REG_FLAP_WINDOW_MS:       cfg_d.flap_window_ms       = wr_i.value;
        REG_CPU_SPIKE_LEVEL:      cfg_d.cpu_spike_level      = wr_i.value[9:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/maq_core.sv */
module maq_core import maq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [NumChannels-1:0] hist_q, hist_d;
  logic [15:0] last_level_q, last_level_d;
  logic [9:0]  last_cpu_q, last_cpu_d;
  logic [15:0] silent_run_q, silent_run_d;
  logic [5:0]  prev_face_q, prev_face_d;
  logic [7:0]  burst_q, burst_d;
  logic [15:0] prev_bright_q, prev_bright_d;
  logic        prev_text_q, prev_text_d;
  logic [31:0] last_toggle_q, last_toggle_d;

  logic        hist;
  res_t        res;

  // Audio
  logic        silent;
  logic [15:0] run_inc;
  logic        dropout;
  logic [1:0]  q_audio;
  logic [16:0] lvl_a, lvl_b;
  logic [32:0] ratio_a, ratio_b;
  logic        jump;

  // Camera
  logic        face_changed;
  logic [7:0]  burst_inc;
  logic        burst_rej;
  logic [15:0] bright_diff;
  logic        bright_rej;

  // Screen and body
  logic        self_rej;
  logic        toggle;
  logic [31:0] since_toggle;
  logic        flap;
  logic        spike;

  assign hist = hist_q[item_i.channel];

  assign silent  = !item_i.voiced && (item_i.raw_rms < cfg_i.silence_level);
  assign run_inc = (silent_run_q == '1) ? silent_run_q : silent_run_q + 16'd1;
  assign dropout = silent && (run_inc >= cfg_i.dropout_count);
  assign q_audio = dropout ? QUAL_DROPOUT : item_i.in_quality;

  // Ratio test on levels offset by one LSB, so a silent previous frame never divides by zero.
  assign lvl_a   = {1'b0, item_i.sample_value} + 17'd1;
  assign lvl_b   = {1'b0, last_level_q} + 17'd1;
  assign ratio_a = 33'(cfg_i.audio_max_ratio) * 33'(lvl_a);
  assign ratio_b = 33'(cfg_i.audio_max_ratio) * 33'(lvl_b);
  assign jump    = hist && (q_audio == QUAL_VALID) &&
                   (({8'b0, lvl_a, 8'b0} > ratio_b) || ({8'b0, lvl_b, 8'b0} > ratio_a));

  assign face_changed = item_i.faces != prev_face_q;
  assign burst_inc    = (burst_q == '1) ? burst_q : burst_q + 8'd1;
  assign burst_rej    = face_changed && (burst_inc > cfg_i.face_burst_limit);
  assign bright_diff  = (item_i.sample_value > prev_bright_q) ?
                        item_i.sample_value - prev_bright_q :
                        prev_bright_q - item_i.sample_value;
  assign bright_rej   = hist && (bright_diff > cfg_i.brightness_max_delta);

  assign self_rej     = cfg_i.ignore_self && item_i.is_self_process;
  assign toggle       = item_i.text_present != prev_text_q;
  assign since_toggle = item_i.now_ms - last_toggle_q;
  assign flap         = since_toggle < {16'b0, cfg_i.flap_window_ms};

  assign spike = (item_i.cpu_load > cfg_i.cpu_spike_level) &&
                 (!hist || (last_cpu_q < CpuHighPrev));

  always_comb begin
    hist_d        = hist_q;
    last_level_d  = last_level_q;
    last_cpu_d    = last_cpu_q;
    silent_run_d  = silent_run_q;
    prev_face_d   = prev_face_q;
    burst_d       = burst_q;
    prev_bright_d = prev_bright_q;
    prev_text_d   = prev_text_q;
    last_toggle_d = last_toggle_q;

    res.quality   = item_i.in_quality;
    res.reason    = REASON_NONE;
    res.out_value = item_i.sample_value;
    res.out_faces = item_i.faces;

    if (item_i.command) begin
      res = '0;
      hist_d[item_i.channel] = 1'b0;
      unique case (item_i.channel)
        CH_AUDIO: begin
          last_level_d = '0;
          silent_run_d = '0;
        end
        CH_CAMERA: begin
          prev_face_d   = '0;
          burst_d       = '0;
          prev_bright_d = '0;
        end
        CH_SCREEN: begin
          prev_text_d   = 1'b0;
          last_toggle_d = '0;
        end
        default: last_cpu_d = '0;
      endcase
    end else begin
      unique case (item_i.channel)
        CH_AUDIO: begin
          silent_run_d = silent ? run_inc : '0;
          if (dropout) begin
            res.quality = QUAL_DROPOUT;
            res.reason  = REASON_DROPOUT;
            if (hist) begin
              res.out_value = last_level_q;
            end
          end
          if (jump) begin
            res.quality = QUAL_REJECTED;
            res.reason  = REASON_LEVEL_JUMP;
          end
        end
        CH_CAMERA: begin
          if (face_changed) begin
            burst_d = burst_inc;
          end else if (burst_q != '0) begin
            burst_d = burst_q - 8'd1;
          end
          if (burst_rej) begin
            res.quality   = QUAL_REJECTED;
            res.reason    = REASON_FACE_BURST;
            res.out_faces = prev_face_q;
          end
          // A brightness jump takes precedence over a face burst for the reason code.
          if (bright_rej) begin
            res.quality = QUAL_REJECTED;
            res.reason  = REASON_BRIGHTNESS;
          end
          prev_face_d   = item_i.faces;
          prev_bright_d = item_i.sample_value;
        end
        CH_SCREEN: begin
          if (self_rej) begin
            res.quality = QUAL_REJECTED;
            res.reason  = REASON_SELF;
          end else begin
            if (toggle) begin
              if (flap) begin
                res.quality = QUAL_REJECTED;
                res.reason  = REASON_FLAP;
              end
              last_toggle_d = item_i.now_ms;
            end
            prev_text_d = item_i.text_present;
          end
        end
        default: begin
          if (spike) begin
            res.quality = QUAL_REJECTED;
            res.reason  = REASON_CPU;
          end
        end
      endcase

      if (res.quality == QUAL_VALID) begin
        hist_d[item_i.channel] = 1'b1;
        if (item_i.channel == CH_AUDIO) begin
          last_level_d = res.out_value;
        end
        if (item_i.channel == CH_BODY) begin
          last_cpu_d = item_i.cpu_load;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q        <= '0;
      last_level_q  <= '0;
      last_cpu_q    <= '0;
      silent_run_q  <= '0;
      prev_face_q   <= '0;
      burst_q       <= '0;
      prev_bright_q <= '0;
      prev_text_q   <= 1'b0;
      last_toggle_q <= '0;
    end else if (fire_i) begin
      hist_q        <= hist_d;
      last_level_q  <= last_level_d;
      last_cpu_q    <= last_cpu_d;
      silent_run_q  <= silent_run_d;
      prev_face_q   <= prev_face_d;
      burst_q       <= burst_d;
      prev_bright_q <= prev_bright_d;
      prev_text_q   <= prev_text_d;
      last_toggle_q <= last_toggle_d;
    end
  end

  assign res_o = res;

endmodule

/* hw/rtl/multi_channel_artifact_qualifier.sv */
// Channel   Direction  Payload    Handshake
// in_i      sink       item_t     valid/ready, taken when both high
// out_o     source     res_t      valid/ready, taken when both high
// cfg_i     sink       cfg_wr_t   valid/ready, ready always high
//
// One item per cycle sustained while out_o does not stall; each item passes from
// acceptance through the input register and then the result register.
// The channel state is read and updated as the item moves from the input register
// into the result register, so the following item always sees the updated state.
// rst_ni clears both valid flags and all channel state and loads register defaults.
// While out_o stalls, one further item is held in the input register before in_i
// drops ready.
module multi_channel_artifact_qualifier import maq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  maq_stream_if.sink   in_i,
  maq_stream_if.source out_o,
  maq_stream_if.sink   cfg_i
);

  item_t item_q;
  logic  in_valid_q;
  res_t  res_q;
  logic  out_valid_q;
  res_t  res;
  cfg_t  cfg;
  logic  out_free;
  logic  move;

  assign out_free   = !out_valid_q || out_o.ready;
  assign move       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || move;
  assign cfg_i.ready = 1'b1;

  maq_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_i       (cfg_i.data),
    .cfg_o      (cfg)
  );

  maq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (move),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
    if (move) begin
      res_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

endmodule

/* hw/rtl/maq_checker.sv */
module maq_checker import maq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input res_t out_data_i
);

  // A result held back by the sink stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or was withdrawn");

  // A newly offered result belongs to an item that was taken at the input and passed through the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a preceding item");

  // Input is never refused while the result side can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input refused although the output is free");

  // Refusing input means both slots are full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without an output stall");

endmodule

bind multi_channel_artifact_qualifier maq_checker u_maq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
